[hw/rtl/i2cmte_pkg.sv]
// types and constants shared by the i2c master transfer engine
`timescale 1ns / 1ps
package i2cmte_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_COMMAND = 2'd1,
    OP_TICK    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_PROBE     = 3'd0,
    KIND_WRITE     = 3'd1,
    KIND_READ      = 3'd2,
    KIND_MEM_WRITE = 3'd3,
    KIND_MEM_READ  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NACK    = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'd0,
    ST_START1    = 5'd1,
    ST_DEVADDR   = 5'd2,
    ST_DEVACK    = 5'd3,
    ST_MEMHI     = 5'd4,
    ST_MEMHIACK  = 5'd5,
    ST_MEMLO     = 5'd6,
    ST_MEMLOACK  = 5'd7,
    ST_DATA      = 5'd8,
    ST_DATAACK   = 5'd9,
    ST_STOPMID   = 5'd10,
    ST_START2    = 5'd11,
    ST_RDADDR    = 5'd12,
    ST_RDADDRACK = 5'd13,
    ST_RDBYTE    = 5'd14,
    ST_RDACK     = 5'd15,
    ST_STOPOK    = 5'd16,
    ST_STOPFAIL  = 5'd17
  } state_t;

  localparam logic [7:0] READ_BIT  = 8'h01;
  localparam logic [7:0] WRITE_MASK = 8'hFE;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic [7:0]  read_data;
    logic        read_valid;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] bytes_done;
  } result_t;

endpackage

[hw/rtl/i2cmte_in_if.sv]
// input channel: load, command and tick transactions
`timescale 1ns / 1ps
interface i2cmte_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [2:0]  transfer_kind;
  logic [7:0]  device_address;
  logic [15:0] memory_address;
  logic        address_wide;
  logic [15:0] byte_count;
  logic [7:0]  write_byte;
  logic        sda_sample;

  modport source (
    output valid, operation, transfer_kind, device_address, memory_address,
           address_wide, byte_count, write_byte, sda_sample,
    input  ready
  );
  modport sink (
    input  valid, operation, transfer_kind, device_address, memory_address,
           address_wide, byte_count, write_byte, sda_sample,
    output ready
  );
endinterface

[hw/rtl/i2cmte_out_if.sv]
// result channel: line drives, read data and transfer status
`timescale 1ns / 1ps
interface i2cmte_out_if;
  logic        valid;
  logic        ready;
  logic        scl_level;
  logic        sda_level;
  logic [7:0]  read_data;
  logic        read_valid;
  logic        busy_res;
  logic        done_res;
  logic [1:0]  status;
  logic [15:0] bytes_done;

  modport source (
    output valid, scl_level, sda_level, read_data, read_valid, busy_res,
           done_res, status, bytes_done,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, read_data, read_valid, busy_res,
           done_res, status, bytes_done,
    output ready
  );
endinterface

[hw/rtl/i2cmte_ram.sv]
// generic single-write, registered-read ram
`timescale 1ns / 1ps
module i2cmte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/i2c_master_transfer_engine.sv]
// i2c master transfer engine top level
//
// channel  | dir | transaction
// item     | in  | load byte, start command or one bus-phase tick
// result   | out | line drives, read byte and status, one per item
//
// one item per cycle while no result is held back, one result per item, set by the single phase state machine
// the result sits in an output register, a new item enters in the cycle the held result leaves
// the write buffer is a ram with a registered read, addressed by the next value of the byte counter
// rst is synchronous; state idle, lines released, buffer empty after reset
// item ready drops only while a result waits and result ready is low
`timescale 1ns / 1ps
module i2c_master_transfer_engine #(
  parameter int BUF_DEPTH = 16
) (
  input logic clk,
  input logic rst,
  i2cmte_in_if.sink    item,
  i2cmte_out_if.source result
);
  import i2cmte_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FW = $clog2(BUF_DEPTH + 1);

  state_t       state, state_next;
  logic [1:0]   phase_count, phase_count_next;
  logic [2:0]   bit_count, bit_count_next;
  logic [15:0]  data_counter, data_counter_next;
  logic [7:0]   shift_reg, shift_reg_next;
  logic         data_fresh, data_fresh_next;
  logic [2:0]   kind_latched, kind_latched_next;
  logic [7:0]   device_latched, device_latched_next;
  logic [15:0]  memaddr_latched, memaddr_latched_next;
  logic         wide_latched, wide_latched_next;
  logic [15:0]  length_latched, length_latched_next;
  logic [FW-1:0] buffer_fill, buffer_fill_next;
  logic         scl_drive, scl_drive_next;
  logic         sda_drive, sda_drive_next;

  logic         res_valid;
  result_t      res, res_next;
  logic         accept;
  logic         buf_wr_en;
  logic [7:0]   buf_rd_data;

  assign item.ready = !res_valid || result.ready;
  assign accept     = item.valid && item.ready;

  i2cmte_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_buf (
    .clk    (clk),
    .wr_en  (buf_wr_en),
    .wr_addr(buffer_fill[AW-1:0]),
    .wr_data(item.write_byte),
    .rd_addr(data_counter_next[AW-1:0]),
    .rd_data(buf_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      phase_count    <= 2'd0;
      bit_count      <= 3'd0;
      data_counter   <= 16'd0;
      shift_reg      <= 8'd0;
      data_fresh     <= 1'b0;
      kind_latched   <= 3'd0;
      device_latched <= 8'd0;
      memaddr_latched <= 16'd0;
      wide_latched   <= 1'b0;
      length_latched <= 16'd0;
      buffer_fill    <= '0;
      scl_drive      <= 1'b1;
      sda_drive      <= 1'b1;
      res_valid      <= 1'b0;
    end else begin
      if (accept) begin
        state          <= state_next;
        phase_count    <= phase_count_next;
        bit_count      <= bit_count_next;
        data_counter   <= data_counter_next;
        shift_reg      <= shift_reg_next;
        data_fresh     <= data_fresh_next;
        kind_latched   <= kind_latched_next;
        device_latched <= device_latched_next;
        memaddr_latched <= memaddr_latched_next;
        wide_latched   <= wide_latched_next;
        length_latched <= length_latched_next;
        buffer_fill    <= buffer_fill_next;
        scl_drive      <= scl_drive_next;
        sda_drive      <= sda_drive_next;
        res_valid      <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  always_comb begin
    logic       send_bit;
    logic [7:0] send_src;
    logic       last;
    logic [16:0] rd_next;

    state_next           = state;
    phase_count_next     = phase_count;
    bit_count_next       = bit_count;
    data_counter_next    = data_counter;
    shift_reg_next       = shift_reg;
    data_fresh_next      = data_fresh;
    kind_latched_next    = kind_latched;
    device_latched_next  = device_latched;
    memaddr_latched_next = memaddr_latched;
    wide_latched_next    = wide_latched;
    length_latched_next  = length_latched;
    buffer_fill_next     = buffer_fill;
    scl_drive_next       = scl_drive;
    sda_drive_next       = sda_drive;
    buf_wr_en            = 1'b0;

    res_next            = '0;
    res_next.scl_level  = scl_drive;
    res_next.sda_level  = sda_drive;

    send_src = data_fresh ? buf_rd_data : shift_reg;
    send_bit = send_src[7];
    rd_next  = {1'b0, data_counter} + 17'd1;
    last     = rd_next >= {1'b0, length_latched};

    if (accept) begin
      unique case (op_t'(item.operation))
        OP_LOAD: begin
          if (state == ST_IDLE && buffer_fill < FW'(BUF_DEPTH)) begin
            buf_wr_en        = 1'b1;
            buffer_fill_next = buffer_fill + FW'(1);
          end
        end
        OP_COMMAND: begin
          if (state == ST_IDLE && item.transfer_kind <= KIND_MEM_READ) begin
            kind_latched_next    = item.transfer_kind;
            device_latched_next  = item.device_address;
            memaddr_latched_next = item.memory_address;
            wide_latched_next    = item.address_wide;
            length_latched_next  = item.byte_count;
            data_counter_next    = 16'd0;
            phase_count_next     = 2'd0;
            bit_count_next       = 3'd0;
            shift_reg_next       = BYTE_ZERO;
            data_fresh_next      = 1'b0;
            if ((item.transfer_kind == KIND_WRITE || item.transfer_kind == KIND_MEM_WRITE)
                && item.byte_count > 16'(BUF_DEPTH)) begin
              res_next.done_res = 1'b1;
              res_next.status   = STATUS_TOO_LONG;
              buffer_fill_next  = '0;
              state_next        = ST_IDLE;
            end else begin
              state_next = ST_START1;
            end
          end
        end
        OP_TICK: begin
          unique case (state)
            ST_IDLE: begin
              scl_drive_next = 1'b1;
              sda_drive_next = 1'b1;
            end
            ST_START1, ST_START2: begin
              scl_drive_next = (phase_count < 2'd2);
              sda_drive_next = (phase_count == 2'd0);
              if (phase_count < 2'd2) begin
                phase_count_next = phase_count + 2'd1;
              end else begin
                phase_count_next = 2'd0;
                bit_count_next   = 3'd0;
                if (state == ST_START2) begin
                  state_next     = ST_RDADDR;
                  shift_reg_next = device_latched | READ_BIT;
                end else if (kind_latched == KIND_READ) begin
                  state_next     = ST_DEVADDR;
                  shift_reg_next = device_latched | READ_BIT;
                end else begin
                  state_next     = ST_DEVADDR;
                  shift_reg_next = device_latched & WRITE_MASK;
                end
              end
            end
            ST_DEVADDR, ST_MEMHI, ST_MEMLO, ST_DATA, ST_RDADDR: begin
              data_fresh_next = 1'b0;
              shift_reg_next  = send_src;
              if (phase_count == 2'd0) begin
                scl_drive_next   = 1'b0;
                sda_drive_next   = send_bit;
                phase_count_next = 2'd1;
              end else if (phase_count == 2'd1) begin
                scl_drive_next   = 1'b1;
                sda_drive_next   = send_bit;
                phase_count_next = 2'd2;
              end else begin
                scl_drive_next   = 1'b0;
                sda_drive_next   = (bit_count == 3'd7) ? 1'b1 : send_bit;
                shift_reg_next   = {send_src[6:0], 1'b0};
                phase_count_next = 2'd0;
                if (bit_count == 3'd7) begin
                  bit_count_next = 3'd0;
                  unique case (state)
                    ST_DEVADDR: state_next = ST_DEVACK;
                    ST_MEMHI:   state_next = ST_MEMHIACK;
                    ST_MEMLO:   state_next = ST_MEMLOACK;
                    ST_DATA:    state_next = ST_DATAACK;
                    default:    state_next = ST_RDADDRACK;
                  endcase
                end else begin
                  bit_count_next = bit_count + 3'd1;
                end
              end
            end
            ST_DEVACK, ST_MEMHIACK, ST_MEMLOACK, ST_DATAACK, ST_RDADDRACK: begin
              sda_drive_next = 1'b1;
              if (phase_count == 2'd0) begin
                scl_drive_next   = 1'b0;
                phase_count_next = 2'd1;
              end else if (phase_count == 2'd1) begin
                scl_drive_next   = 1'b1;
                shift_reg_next   = {7'd0, item.sda_sample};
                phase_count_next = 2'd2;
              end else begin
                scl_drive_next   = 1'b0;
                phase_count_next = 2'd0;
                bit_count_next   = 3'd0;
                shift_reg_next   = BYTE_ZERO;
                if (shift_reg[0]) begin
                  state_next = ST_STOPFAIL;
                end else begin
                  if (state == ST_DATAACK) begin
                    data_counter_next = data_counter + 16'd1;
                  end
                  unique case (state)
                    ST_DEVACK: begin
                      if (kind_latched == KIND_PROBE) begin
                        state_next = ST_STOPOK;
                      end else if (kind_latched == KIND_WRITE) begin
                        state_next = ST_DATA;
                      end else if (kind_latched == KIND_READ) begin
                        state_next = ST_RDBYTE;
                      end else if (wide_latched) begin
                        state_next     = ST_MEMHI;
                        shift_reg_next = memaddr_latched[15:8];
                      end else begin
                        state_next     = ST_MEMLO;
                        shift_reg_next = memaddr_latched[7:0];
                      end
                    end
                    ST_MEMHIACK: begin
                      state_next     = ST_MEMLO;
                      shift_reg_next = memaddr_latched[7:0];
                    end
                    ST_MEMLOACK: begin
                      state_next = (kind_latched == KIND_MEM_WRITE) ? ST_DATA : ST_STOPMID;
                    end
                    ST_DATAACK:   state_next = ST_DATA;
                    default:      state_next = ST_RDBYTE;
                  endcase
                  if (state_next == ST_DATA) begin
                    if (data_counter_next < length_latched) begin
                      data_fresh_next = 1'b1;
                    end else begin
                      state_next = ST_STOPOK;
                    end
                  end else if (state_next == ST_RDBYTE &&
                               data_counter_next >= length_latched) begin
                    state_next = ST_STOPOK;
                  end
                end
              end
            end
            ST_RDBYTE: begin
              sda_drive_next = 1'b1;
              if (phase_count == 2'd0) begin
                scl_drive_next   = 1'b1;
                shift_reg_next   = {shift_reg[6:0], item.sda_sample};
                phase_count_next = 2'd1;
                if (bit_count == 3'd7) begin
                  res_next.read_data  = {shift_reg[6:0], item.sda_sample};
                  res_next.read_valid = 1'b1;
                end
              end else begin
                scl_drive_next   = 1'b0;
                phase_count_next = 2'd0;
                if (bit_count == 3'd7) begin
                  bit_count_next = 3'd0;
                  state_next     = ST_RDACK;
                end else begin
                  bit_count_next = bit_count + 3'd1;
                end
              end
            end
            ST_RDACK: begin
              scl_drive_next = (phase_count == 2'd1);
              sda_drive_next = last;
              if (phase_count < 2'd2) begin
                phase_count_next = phase_count + 2'd1;
              end else begin
                data_counter_next = rd_next[15:0];
                phase_count_next  = 2'd0;
                bit_count_next    = 3'd0;
                shift_reg_next    = BYTE_ZERO;
                state_next        = last ? ST_STOPOK : ST_RDBYTE;
              end
            end
            ST_STOPMID, ST_STOPOK, ST_STOPFAIL: begin
              scl_drive_next   = 1'b1;
              sda_drive_next   = 1'b1;
              phase_count_next = 2'd0;
              bit_count_next   = 3'd0;
              shift_reg_next   = BYTE_ZERO;
              if (state == ST_STOPMID) begin
                data_counter_next = 16'd0;
                state_next        = ST_START2;
              end else begin
                state_next        = ST_IDLE;
                res_next.done_res = 1'b1;
                if (kind_latched == KIND_WRITE || kind_latched == KIND_MEM_WRITE) begin
                  buffer_fill_next = '0;
                end
                if (state == ST_STOPFAIL) begin
                  res_next.status = STATUS_NACK;
                end else begin
                  res_next.status     = STATUS_OK;
                  res_next.bytes_done = (kind_latched == KIND_PROBE) ? 16'd0 : length_latched;
                end
              end
            end
            default: begin
              scl_drive_next = 1'b1;
              sda_drive_next = 1'b1;
            end
          endcase
          res_next.scl_level = scl_drive_next;
          res_next.sda_level = sda_drive_next;
          if (state == ST_STOPMID || state == ST_STOPOK || state == ST_STOPFAIL) begin
            res_next.scl_level = 1'b1;
            res_next.sda_level = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    res_next.busy_res = (state_next != ST_IDLE);
  end

  assign result.valid      = res_valid;
  assign result.scl_level  = res.scl_level;
  assign result.sda_level  = res.sda_level;
  assign result.read_data  = res.read_data;
  assign result.read_valid = res.read_valid;
  assign result.busy_res   = res.busy_res;
  assign result.done_res   = res.done_res;
  assign result.status     = res.status;
  assign result.bytes_done = res.bytes_done;

endmodule

[hw/rtl/i2cmte_chk.sv]
// port-level checker for the i2c master transfer engine, with its bind
`timescale 1ns / 1ps
module i2cmte_chk (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        scl_level,
  input logic        sda_level,
  input logic        read_valid,
  input logic        busy_res,
  input logic        done_res,
  input logic [1:0]  status,
  input logic [15:0] bytes_done
);
  import i2cmte_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(done_res) && $stable(status))
    else $error("stalled result changed");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> !busy_res)
    else $error("done with busy still set");

  a_status_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && !done_res |-> status == STATUS_OK && bytes_done == 16'd0)
    else $error("status without done");

  a_read_scl_high: assert property (@(posedge clk) disable iff (rst)
    res_valid && read_valid |-> busy_res && scl_level && sda_level && !done_res)
    else $error("read byte outside a read phase");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res && status != STATUS_OK |-> bytes_done == 16'd0)
    else $error("failed transfer reports bytes");

endmodule

bind i2c_master_transfer_engine i2cmte_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .scl_level (result.scl_level),
  .sda_level (result.sda_level),
  .read_valid(result.read_valid),
  .busy_res  (result.busy_res),
  .done_res  (result.done_res),
  .status    (result.status),
  .bytes_done(result.bytes_done)
);
